// ----- design/abwp_pkg.sv -----
// Package with the item types, register indexes and per-stage logic of the window planner.
package abwp_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_IDX_ALIGN = 8'd0;
  localparam logic [7:0] CFG_IDX_LIMIT = 8'd1;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [31:0] ALIGN_RST = 32'd256;
  localparam logic [31:0] LIMIT_RST = 32'd134217728;

  // Pipeline stage map.
  localparam int unsigned NUM_STAGES = 35;
  localparam int unsigned STG_W = 6;
  localparam logic [STG_W-1:0] ST_CHECK    = 6'd0;
  localparam logic [STG_W-1:0] ST_START    = 6'd1;
  localparam logic [STG_W-1:0] ST_OFFSET   = 6'd2;
  localparam logic [STG_W-1:0] ST_BOUNDS   = 6'd3;
  localparam logic [STG_W-1:0] ST_MOD0     = 6'd4;
  localparam logic [STG_W-1:0] ST_MODLAST  = 6'd19;
  localparam logic [STG_W-1:0] ST_LEAD     = 6'd20;
  localparam logic [STG_W-1:0] ST_DIV0     = 6'd21;
  localparam logic [STG_W-1:0] ST_DIVLAST  = 6'd28;
  localparam logic [STG_W-1:0] ST_COUNT    = 6'd29;
  localparam logic [STG_W-1:0] ST_TAILPP   = 6'd30;
  localparam logic [STG_W-1:0] ST_TAIL     = 6'd31;
  localparam logic [STG_W-1:0] ST_SPAN     = 6'd32;
  localparam logic [STG_W-1:0] ST_WINDOW   = 6'd33;
  localparam logic [STG_W-1:0] ST_LIMIT    = 6'd34;

  typedef struct packed {
    logic        cmd;
    logic [63:0] first_element;
    logic [63:0] request_count;
    logic [63:0] array_elements;
    logic [63:0] element_size;
    logic [63:0] element_stride;
    logic [63:0] array_offset;
    logic [63:0] buffer_size;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] window_base;
    logic [31:0] window_bytes;
    logic [31:0] lead_offset;
    logic [63:0] window_count;
  } out_item_t;

  // Working context that travels down the pipeline.
  typedef struct packed {
    logic        cmd;
    logic        ok;
    logic [63:0] first;
    logic [63:0] req;
    logic [63:0] total;
    logic [63:0] esz;
    logic [63:0] stride;
    logic [63:0] aoff;
    logic [63:0] bsize;
    logic [63:0] avail;
    logic [63:0] ll;
    logic [63:0] mid;
    logic [63:0] off;
    logic [31:0] rem;
    logic [31:0] dvd;
    logic [31:0] drem;
    logic [31:0] quo;
    logic [63:0] cnt;
    logic [63:0] tail;
  } ctx_t;

  function automatic ctx_t ctx_from_item(input in_item_t it);
    ctx_t c;
    c        = '0;
    c.cmd    = it.cmd;
    c.first  = it.first_element;
    c.req    = it.request_count;
    c.total  = it.array_elements;
    c.esz    = it.element_size;
    c.stride = it.element_stride;
    c.aoff   = it.array_offset;
    c.bsize  = it.buffer_size;
    return c;
  endfunction

  // Partial products of a 64x64 multiply whose result must fit 64 bits.
  // Only one cross term can be nonzero when the high halves are not both set.
  function automatic ctx_t mul_pp(input ctx_t c, input logic [63:0] a, input logic [63:0] b);
    ctx_t r;
    logic a_hi;
    r      = c;
    a_hi   = (a[63:32] != 32'd0);
    r.ll   = 64'(a[31:0]) * 64'(b[31:0]);
    r.mid  = a_hi ? 64'(a[63:32]) * 64'(b[31:0]) : 64'(a[31:0]) * 64'(b[63:32]);
    r.ok   = c.ok & ~(a_hi & (b[63:32] != 32'd0));
    return r;
  endfunction

  // Combine the partial products; the flag reports a 64-bit overflow.
  function automatic logic [64:0] mul_join(input logic [63:0] ll, input logic [63:0] mid);
    logic [64:0] s;
    s = {1'b0, ll} + {1'b0, mid[31:0], 32'd0};
    return {s[64] | (mid[63:32] != 32'd0), s[63:0]};
  endfunction

  // Four restoring steps of a remainder against a 32-bit divisor.
  function automatic logic [63:0] div_step4(input logic [31:0] rem, input logic [31:0] quo,
                                            input logic [3:0] bits, input logic [31:0] dsr);
    logic [32:0] t;
    logic [31:0] r;
    logic [31:0] q;
    r = rem;
    q = quo;
    for (int i = 3; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, dsr}) begin
        t = t - {1'b0, dsr};
        q = {q[30:0], 1'b1};
      end else begin
        q = {q[30:0], 1'b0};
      end
      r = t[31:0];
    end
    return {r, q};
  endfunction

  // Logic of one pipeline stage, applied as an item enters that stage.
  function automatic ctx_t stage_fn(input logic [STG_W-1:0] k, input ctx_t c,
                                    input logic [31:0] align, input logic [31:0] limit);
    ctx_t r;
    logic [64:0] s;
    logic [63:0] ds;
    logic [63:0] left;
    logic [63:0] cap;
    logic [32:0] q1;
    logic [STG_W-1:0] j;
    logic [5:0] pos;
    logic [31:0] room;
    r = c;
    case (k)
      ST_CHECK: begin
        r.ok = (align != 32'd0) && (limit != 32'd0) && (c.esz != 64'd0) &&
               (c.stride >= c.esz) &&
               (c.cmd ? (c.first < c.total)
                      : ((c.req != 64'd0) && (c.first <= c.total) &&
                         (c.req <= c.total - c.first)));
        r = mul_pp(r, c.first, c.stride);
      end
      ST_START: begin
        s     = mul_join(c.ll, c.mid);
        r.off = s[63:0];
        r.ok  = c.ok & ~s[64];
      end
      ST_OFFSET: begin
        s     = {1'b0, c.aoff} + {1'b0, c.off};
        r.off = s[63:0];
        r.ok  = c.ok & ~s[64];
      end
      ST_BOUNDS: begin
        r.avail = c.bsize - c.off;
        r.ok    = c.ok && (c.off <= c.bsize) && (!c.cmd || (c.esz <= c.bsize - c.off));
        r.rem   = 32'd0;
      end
      ST_LEAD: begin
        r.off = c.off - {32'd0, c.rem};
        if (c.cmd) begin
          r.ok = c.ok && (c.rem <= limit) && (c.esz <= {32'd0, limit - c.rem});
        end
        room   = limit - c.rem - c.esz[31:0];
        r.dvd  = (c.stride[63:32] != 32'd0) ? 32'd0 : room;
        r.drem = 32'd0;
        r.quo  = 32'd0;
      end
      ST_COUNT: begin
        q1   = {1'b0, c.quo} + 33'd1;
        cap  = (c.stride[63:32] != 32'd0) ? 64'd1 : {31'd0, q1};
        left = c.total - c.first;
        r.cnt = c.cmd ? ((left < cap) ? left : cap) : c.req;
      end
      ST_TAILPP: begin
        r = mul_pp(c, c.cnt - 64'd1, c.stride);
      end
      ST_TAIL: begin
        s      = mul_join(c.ll, c.mid);
        r.tail = s[63:0];
        r.ok   = c.ok & ~s[64];
      end
      ST_SPAN: begin
        s      = {1'b0, c.tail} + {1'b0, c.esz};
        r.tail = s[63:0];
        r.ok   = c.ok & ~s[64];
      end
      ST_WINDOW: begin
        s      = {1'b0, c.tail} + {33'd0, c.rem};
        r.tail = s[63:0];
        r.ok   = c.ok && !s[64] && (c.tail <= c.avail);
      end
      ST_LIMIT: begin
        r.ok = c.ok && (c.tail <= {32'd0, limit});
      end
      default: begin
        // Remainder stages walk the offset, quotient stages walk the room.
        if (k >= ST_MOD0 && k <= ST_MODLAST) begin
          j   = k - ST_MOD0;
          pos = 6'd63 - {j[3:0], 2'b00};
          ds  = div_step4(c.rem, 32'd0, c.off[pos -: 4], align);
          r.rem = ds[63:32];
        end else if (k >= ST_DIV0 && k <= ST_DIVLAST) begin
          j   = k - ST_DIV0;
          pos = 6'd31 - {1'b0, j[2:0], 2'b00};
          ds  = div_step4(c.drem, c.quo, c.dvd[pos[4:0] -: 4], c.stride[31:0]);
          r.drem = ds[63:32];
          r.quo  = ds[31:0];
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ----- design/aligned_buffer_window_planner_core.sv -----
// Top level of the aligned buffer window planner: configuration, pipeline and result register.
//
// Usage: each request on in_data describes a strided array inside a buffer and
// asks for one window over it (cmd 0: a given element count, cmd 1: as many
// elements as fit the window limit). Each request yields exactly one result on
// out_data; valid_res is low and all other fields are zero when it is rejected.
// A transfer happens on a channel at a clock edge where valid is high and stall
// is low. The cfg port writes offset_alignment (index 0) and window_limit
// (index 1); cfg_ready is always high and writes to other indexes are ignored.
// Registers should only be written while no request is in flight.
// The 35-stage pipeline (16 remainder stages for the alignment and 8 quotient
// stages for the fit count, four bits each) is followed by the result register.
// One request is accepted every cycle while in_stall is low. When the receiver
// stalls, stages ahead of the first empty one hold; in_stall rises only once
// every stage holds an item. Reset (rst_n low, synchronous) empties the
// pipeline and restores the registers to an alignment of 256 bytes and a
// limit of 128 MiB.
module aligned_buffer_window_planner_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  abwp_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output abwp_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [abwp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import abwp_pkg::*;

  logic [31:0] align_r;
  logic [31:0] limit_r;
  logic [NUM_STAGES-1:0] stg_valid_r;
  ctx_t                  stg_r [NUM_STAGES];
  ctx_t                  stg_nxt [NUM_STAGES];
  logic [NUM_STAGES:0]   adv;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  out_item_t             out_data_nxt;
  ctx_t                  last;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= ALIGN_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_ALIGN) begin
        align_r <= cfg_data;
      end else if (cfg_index == CFG_IDX_LIMIT) begin
        limit_r <= cfg_data;
      end
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[NUM_STAGES] = !out_valid_r || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !stg_valid_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  // Next contents of every stage.
  always_comb begin
    stg_nxt[0] = stage_fn(ST_CHECK, ctx_from_item(in_data), align_r, limit_r);
    for (int k = 1; k < NUM_STAGES; k++) begin
      stg_nxt[k] = stage_fn(STG_W'(k), stg_r[k-1], align_r, limit_r);
    end
  end

  // Stage registers; valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= '0;
    end else begin
      if (adv[0]) begin
        stg_valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          stg_valid_r[k] <= stg_valid_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // Result formatting; a rejected request shows all zeros.
  always_comb begin
    last         = stg_r[NUM_STAGES-1];
    out_data_nxt = '0;
    if (last.ok) begin
      out_data_nxt.valid_res    = 1'b1;
      out_data_nxt.window_base  = last.off;
      out_data_nxt.window_bytes = last.tail[31:0];
      out_data_nxt.lead_offset  = last.rem;
      out_data_nxt.window_count = last.cnt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv[NUM_STAGES]) begin
      out_valid_r <= stg_valid_r[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NUM_STAGES]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The input is only held off when the first stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stg_valid_r[0])
    else $error("input stalled with an empty first stage");

  // A free output never backs up the pipeline.
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output was free");

  // A rejected result carries only zeros.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.valid_res) |->
      (out_data_r.window_base == 64'd0 && out_data_r.window_bytes == 32'd0 &&
       out_data_r.lead_offset == 32'd0 && out_data_r.window_count == 64'd0))
    else $error("rejected result with nonzero fields");

  // A planned window covers elements and stays within the limit.
  a_plan_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.valid_res) |->
      (out_data_r.window_count != 64'd0 && out_data_r.window_bytes <= limit_r &&
       out_data_r.lead_offset < out_data_r.window_bytes))
    else $error("planned window out of range");

endmodule

// ----- bench/aligned_buffer_window_planner_core_tb.sv -----
// Testbench for the aligned buffer window planner: directed table, random requests, scoreboard.
module aligned_buffer_window_planner_core_tb;
  import abwp_pkg::*;

  localparam int unsigned LATENCY = 36;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned DIRECTED_ITEMS = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  aligned_buffer_window_planner_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the two registers.
  logic [63:0] align_q = 64'd256;
  logic [63:0] limit_q = 64'd134217728;

  out_item_t plan_queue[$];
  int unsigned mismatches = 0;
  int unsigned hold_off = 0;

  // One directed row: request, and optionally a typed-in expected plan.
  typedef struct {
    in_item_t req;
    bit has_plan;
    out_item_t plan;
  } row_t;
  row_t rows[DIRECTED_ITEMS];

  function automatic bit mul_fits(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[127:64] == 64'd0;
  endfunction

  function automatic bit add_fits(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return !s[64];
  endfunction

  // Window with a known element count; returns zero plan when rejected.
  function automatic out_item_t plan_count(input in_item_t r, input logic [63:0] cnt);
    out_item_t p;
    logic [63:0] start, tail, off, span, base, lead;
    p = '0;
    if (align_q == 0 || limit_q == 0 || r.element_size == 0 ||
        r.element_stride < r.element_size || cnt == 0 ||
        r.first_element > r.array_elements || cnt > r.array_elements - r.first_element)
      return p;
    if (!mul_fits(r.first_element, r.element_stride) || !mul_fits(cnt - 1, r.element_stride))
      return p;
    start = r.first_element * r.element_stride;
    tail = (cnt - 1) * r.element_stride;
    if (!add_fits(r.array_offset, start) || !add_fits(tail, r.element_size)) return p;
    off = r.array_offset + start;
    span = tail + r.element_size;
    if (off > r.buffer_size || span > r.buffer_size - off) return p;
    base = off - off % align_q;
    lead = off - base;
    if (!add_fits(lead, span) || lead + span > limit_q) return p;
    p.valid_res = 1'b1;
    p.window_base = base;
    p.window_bytes = 32'(lead + span);
    p.lead_offset = 32'(lead);
    p.window_count = cnt;
    return p;
  endfunction

  // Predicted result of one request in either mode.
  function automatic out_item_t plan_window(input in_item_t r);
    logic [63:0] off, lead, room, cap, left;
    if (!r.cmd) return plan_count(r, r.request_count);
    if (align_q == 0 || limit_q == 0 || r.element_size == 0 ||
        r.element_stride < r.element_size || r.first_element >= r.array_elements)
      return '0;
    if (!mul_fits(r.first_element, r.element_stride) ||
        !add_fits(r.array_offset, r.first_element * r.element_stride))
      return '0;
    off = r.array_offset + r.first_element * r.element_stride;
    if (off > r.buffer_size || r.element_size > r.buffer_size - off) return '0;
    lead = off % align_q;
    if (lead > limit_q || r.element_size > limit_q - lead) return '0;
    room = limit_q - lead - r.element_size;
    cap = 1 + room / r.element_stride;
    left = r.array_elements - r.first_element;
    return plan_count(r, (left < cap) ? left : cap);
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 300));
    endcase
  endfunction

  // Mostly well-formed layouts with small values; some full-range noise.
  function automatic in_item_t random_request();
    in_item_t r;
    r.cmd = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 8) begin
      r.element_size = 64'($urandom_range(1, 64));
      r.element_stride = r.element_size + 64'($urandom_range(0, 64));
      r.array_elements = 64'($urandom_range(1, 2000));
      r.first_element = 64'($urandom_range(0, 32'(r.array_elements) - 1));
      r.request_count = 64'($urandom_range(1, 32'(r.array_elements - r.first_element)));
      r.array_offset = 64'($urandom_range(0, 5000));
      r.buffer_size = r.array_offset + r.array_elements * r.element_stride
                      - 64'($urandom_range(0, 100));
      if ($urandom_range(0, 7) == 0) r.request_count = r.request_count + 1;
      if ($urandom_range(0, 15) == 0) r.array_offset = {$urandom, $urandom};
    end else begin
      r.first_element = pick64();
      r.request_count = pick64();
      r.array_elements = pick64();
      r.element_size = pick64();
      r.element_stride = pick64();
      r.array_offset = pick64();
      r.buffer_size = pick64();
    end
    return r;
  endfunction

  function automatic in_item_t mk(input logic c, input logic [63:0] f, input logic [63:0] q,
                                  input logic [63:0] n, input logic [63:0] es,
                                  input logic [63:0] st, input logic [63:0] ao,
                                  input logic [63:0] bs);
    in_item_t r;
    r = '{c, f, q, n, es, st, ao, bs};
    return r;
  endfunction

  // One register write; valid drops at the next falling edge after it is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_IDX_ALIGN) align_q = {32'd0, val};
    else align_q = align_q;
    if (idx == CFG_IDX_LIMIT) limit_q = {32'd0, val};
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every expected plan has come back, plus the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (plan_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Offer one request; it transfers at a rising edge without stall.
  // Valid stays high into the next request unless a gap is inserted.
  task automatic send_request(input in_item_t r, input bit has_plan, input out_item_t plan);
    int unsigned gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    plan_queue.push_back(has_plan ? plan : plan_window(r));
    @(negedge clk);
  endtask

  // Receiver: random stalls, with one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_off != 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every result transfer with the oldest expected plan.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (plan_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        want = plan_queue.pop_front();
        if (out_data.valid_res !== want.valid_res ||
            out_data.window_base !== want.window_base ||
            out_data.window_bytes !== want.window_bytes ||
            out_data.lead_offset !== want.lead_offset ||
            out_data.window_count !== want.window_count) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // Main sequence: reset, directed table, a hold-off phase, register phases with random requests.
  initial begin
    out_item_t none;
    logic [31:0] aligns[5];
    logic [31:0] limits[5];
    none = '0;
    aligns = '{32'd256, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd64};
    limits = '{32'd134217728, 32'hFFFF_FFFF, 32'd1, 32'd300, 32'd0};
    rows[0] = '{mk(0, 0, 1, 1, 4, 4, 0, 4), 1, '{1'b1, 64'd0, 32'd4, 32'd0, 64'd1}};
    rows[1] = '{mk(0, 0, 0, 10, 4, 4, 0, 100), 1, none};
    rows[2] = '{mk(0, 0, 1, 10, 0, 4, 0, 100), 1, none};
    rows[3] = '{mk(0, 0, 1, 10, 8, 4, 0, 100), 1, none};
    rows[4] = '{mk(0, 5, 6, 10, 4, 4, 0, 100), 1, none};
    rows[5] = '{mk(1, 10, 1, 10, 4, 4, 0, 100), 1, none};
    rows[6] = '{mk(0, 1, 1, 10, 4, 4, 300, 400), 1,
                '{1'b1, 64'd256, 32'd52, 32'd48, 64'd1}};
    rows[7] = '{mk(0, 0, 2, '1, 4, '1, 0, '1), 1, none};
    rows[8] = '{mk(0, '1, 1, '1, 4, 4, 0, '1), 1, none};
    rows[9] = '{mk(0, 0, 1, 1, 4, 4, '1, '1), 1, none};
    rows[10] = '{mk(0, 0, 1, 10, 4, 4, 98, 100), 1, none};
    rows[11] = '{mk(0, 0, 64'd40000000, 64'd40000000, 4, 4, 0, '1), 1, none};
    rows[12] = '{mk(1, 0, 0, 10, 4, 4, 0, 100), 1,
                 '{1'b1, 64'd0, 32'd40, 32'd0, 64'd10}};
    rows[13] = '{mk(1, 0, 0, '1, 1, 1, 0, '1), 0, none};
    rows[14] = '{mk(1, 3, 0, 100, 7, 13, 5, 2000), 0, none};
    rows[15] = '{mk(1, 0, 0, 1, 64'd200000000, 64'd200000000, 0, '1), 1, none};
    rows[16] = '{mk(0, '1, '1, '1, '1, '1, '1, '1), 1, none};
    rows[17] = '{mk(1, 0, 0, '1, 1, 64'h1_0000_0000, 0, '1), 0, none};
    rows[18] = '{mk(0, 2, 3, 9, 5, 9, 1000, 5000), 0, none};
    rows[19] = '{mk(1, 7, '1, 8, 64'd100, 64'd100, 64'd77, 64'd10000), 0, none};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_request(rows[i].req, rows[i].has_plan, rows[i].plan);
    drain();
    // Long receiver hold-off while requests keep coming so the pipeline fills.
    hold_off = 150;
    for (int i = 0; i < 60; i++) send_request(random_request(), 0, none);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_IDX_ALIGN, aligns[p]);
      write_reg(CFG_IDX_LIMIT, limits[(p + 2) % 5]);
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) send_request(random_request(), 0, none);
      drain();
    end
    write_reg(CFG_IDX_ALIGN, 32'd4096);
    write_reg(CFG_IDX_LIMIT, 32'd1000);
    for (int i = 0; i < 40; i++) send_request(random_request(), 0, none);
    drain();
    if (mismatches == 0 && plan_queue.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
